// ===== design/wdb_pkg.sv =====
// ----------------------------------------------------------------------------
// wdb_pkg : shared constants and types of the Wiener deconvolution bin
// Field widths, fixed-point position, register reset value and the flags
// carried along the divider cell chain.
// ----------------------------------------------------------------------------
package wdb_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int BIAS_W         = 32;

    localparam logic [BIAS_W-1:0] NOISE_BIAS_RST = 32'd655;

    // width of |K|^2 + bias, with one spare bit
    function automatic int den_width(input int w);
        return ((2 * w > BIAS_W + FRAC_BITS) ? 2 * w : BIAS_W + FRAC_BITS) + 1;
    endfunction

    typedef struct packed {
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
        logic zero_den;
    } t_flags;

endpackage

// ===== design/wdb_in_if.sv =====
// ----------------------------------------------------------------------------
// wdb_in_if : input bin channel
// Valid/ready channel carrying one spectrum bin and one kernel bin.
// ----------------------------------------------------------------------------
interface wdb_in_if #(
    parameter int DATA_WIDTH = wdb_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] spec_re;
    logic signed [DATA_WIDTH-1:0] spec_im;
    logic signed [DATA_WIDTH-1:0] kern_re;
    logic signed [DATA_WIDTH-1:0] kern_im;

    modport source (output valid, output spec_re, output spec_im,
                    output kern_re, output kern_im, input ready);
    modport sink   (input valid, input spec_re, input spec_im,
                    input kern_re, input kern_im, output ready);
endinterface

// ===== design/wdb_out_if.sv =====
// ----------------------------------------------------------------------------
// wdb_out_if : restored bin channel
// Valid/ready channel carrying the restored bin and its status flags.
// ----------------------------------------------------------------------------
interface wdb_out_if #(
    parameter int DATA_WIDTH = wdb_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_re;
    logic signed [DATA_WIDTH-1:0] out_im;
    logic                         sat_flag;
    logic                         zero_div_flag;

    modport source (output valid, output out_re, output out_im,
                    output sat_flag, output zero_div_flag, input ready);
    modport sink   (input valid, input out_re, input out_im,
                    input sat_flag, input zero_div_flag, output ready);
endinterface

// ===== design/wdb_front.sv =====
// ----------------------------------------------------------------------------
// wdb_front : products, sums and divider set-up
// Four stages: sign/magnitude split, six products, numerator and
// denominator sums, overflow check and first partial remainder.
// ----------------------------------------------------------------------------
module wdb_front #(
    parameter int DATA_WIDTH = wdb_pkg::DATA_WIDTH_DEF,
    localparam int DEN_W     = wdb_pkg::den_width(DATA_WIDTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_adv,
    input  logic signed [DATA_WIDTH-1:0]    i_spec_re,
    input  logic signed [DATA_WIDTH-1:0]    i_spec_im,
    input  logic signed [DATA_WIDTH-1:0]    i_kern_re,
    input  logic signed [DATA_WIDTH-1:0]    i_kern_im,
    input  logic [wdb_pkg::BIAS_W-1:0]      i_noise_bias,
    input  logic                            i_adv,
    output logic                            o_valid,
    output wdb_pkg::t_flags                 o_flags,
    output logic [DEN_W-1:0]                o_den,
    output logic [DEN_W-1:0]                o_rem_re,
    output logic [DEN_W-1:0]                o_rem_im,
    output logic [DATA_WIDTH-1:0]           o_lo_re,
    output logic [DATA_WIDTH-1:0]           o_lo_im
);

    localparam int W  = DATA_WIDTH;
    localparam int FB = wdb_pkg::FRAC_BITS;
    localparam int NW = 2 * W + FB;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [2*W:0] sm_add(input logic [2*W-1:0] x, input logic xn,
                                            input logic [2*W-1:0] y, input logic yn);
        logic [2*W-1:0] r;
        logic           rn;
        if (xn == yn) begin
            r  = x + y;
            rn = xn;
        end else if (x >= y) begin
            r  = x - y;
            rn = xn;
        end else begin
            r  = y - x;
            rn = yn;
        end
        return {rn && (r != '0), r};
    endfunction

    logic adv1, adv2, adv3, adv4;

    logic           r1_valid;
    logic [W-1:0]   r1_a, r1_b, r1_c, r1_d;
    logic           r1_an, r1_bn, r1_cn, r1_dn;

    logic           r2_valid;
    logic [2*W-1:0] r2_ac, r2_bd, r2_bc, r2_ad, r2_cc, r2_dd;
    logic           r2_n1, r2_n2, r2_n3, r2_n4;

    logic           r3_valid;
    logic [2*W-1:0] r3_mag_re, r3_mag_im;
    logic           r3_neg_re, r3_neg_im;
    logic [DEN_W-1:0] r3_den;

    logic           r4_valid;
    wdb_pkg::t_flags r4_flags;
    logic [DEN_W-1:0] r4_den, r4_rem_re, r4_rem_im;
    logic [W-1:0]   r4_lo_re, r4_lo_im;

    logic [2*W:0]   n3_re, n3_im;
    logic [NW-1:0]  n4_num_re, n4_num_im;
    logic [DEN_W-1:0] n4_hi_re, n4_hi_im;

    assign adv4  = !r4_valid || i_adv;
    assign adv3  = !r3_valid || adv4;
    assign adv2  = !r2_valid || adv3;
    assign adv1  = !r1_valid || adv2;
    assign o_adv = adv1;

    assign n3_re = sm_add(r2_ac, r2_n1, r2_bd, r2_n2);
    assign n3_im = sm_add(r2_bc, r2_n3, r2_ad, r2_n4);

    assign n4_num_re = {r3_mag_re, {FB{1'b0}}};
    assign n4_num_im = {r3_mag_im, {FB{1'b0}}};
    assign n4_hi_re  = DEN_W'(n4_num_re[NW-1:W]);
    assign n4_hi_im  = DEN_W'(n4_num_im[NW-1:W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (adv1) r1_valid <= i_valid;
            if (adv2) r2_valid <= r1_valid;
            if (adv3) r3_valid <= r2_valid;
            if (adv4) r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_a  <= mag_of(i_spec_re);
            r1_b  <= mag_of(i_spec_im);
            r1_c  <= mag_of(i_kern_re);
            r1_d  <= mag_of(i_kern_im);
            r1_an <= i_spec_re[W-1];
            r1_bn <= i_spec_im[W-1];
            r1_cn <= i_kern_re[W-1];
            r1_dn <= i_kern_im[W-1];
        end
        if (adv2) begin
            r2_ac <= r1_a * r1_c;
            r2_bd <= r1_b * r1_d;
            r2_bc <= r1_b * r1_c;
            r2_ad <= r1_a * r1_d;
            r2_cc <= r1_c * r1_c;
            r2_dd <= r1_d * r1_d;
            r2_n1 <= r1_an ^ r1_cn;
            r2_n2 <= r1_bn ^ r1_dn;
            r2_n3 <= r1_bn ^ r1_cn;
            r2_n4 <= !(r1_an ^ r1_dn);
        end
        if (adv3) begin
            r3_mag_re <= n3_re[2*W-1:0];
            r3_neg_re <= n3_re[2*W];
            r3_mag_im <= n3_im[2*W-1:0];
            r3_neg_im <= n3_im[2*W];
            r3_den    <= DEN_W'(r2_cc) + DEN_W'(r2_dd)
                       + DEN_W'({i_noise_bias, {FB{1'b0}}});
        end
        if (adv4) begin
            r4_flags.neg_re   <= r3_neg_re;
            r4_flags.neg_im   <= r3_neg_im;
            r4_flags.ovf_re   <= n4_hi_re >= r3_den;
            r4_flags.ovf_im   <= n4_hi_im >= r3_den;
            r4_flags.zero_den <= r3_den == '0;
            r4_den            <= r3_den;
            r4_rem_re         <= n4_hi_re;
            r4_rem_im         <= n4_hi_im;
            r4_lo_re          <= n4_num_re[W-1:0];
            r4_lo_im          <= n4_num_im[W-1:0];
        end
    end

    assign o_valid  = r4_valid;
    assign o_flags  = r4_flags;
    assign o_den    = r4_den;
    assign o_rem_re = r4_rem_re;
    assign o_rem_im = r4_rem_im;
    assign o_lo_re  = r4_lo_re;
    assign o_lo_im  = r4_lo_im;

endmodule

// ===== design/wdb_cell.sv =====
// ----------------------------------------------------------------------------
// wdb_cell : one restoring division step
// Develops one quotient bit of the real and of the imaginary quotient and
// hands remainder, dividend bits and quotient to the next cell.
// ----------------------------------------------------------------------------
module wdb_cell #(
    parameter int DATA_WIDTH = wdb_pkg::DATA_WIDTH_DEF,
    localparam int DEN_W     = wdb_pkg::den_width(DATA_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  wdb_pkg::t_flags       i_flags,
    input  logic [DEN_W-1:0]      i_den,
    input  logic [DEN_W-1:0]      i_rem_re,
    input  logic [DEN_W-1:0]      i_rem_im,
    input  logic [DATA_WIDTH-1:0] i_lo_re,
    input  logic [DATA_WIDTH-1:0] i_lo_im,
    input  logic [DATA_WIDTH-1:0] i_q_re,
    input  logic [DATA_WIDTH-1:0] i_q_im,
    input  logic                  i_adv,
    output logic                  o_adv,
    output logic                  o_valid,
    output wdb_pkg::t_flags       o_flags,
    output logic [DEN_W-1:0]      o_den,
    output logic [DEN_W-1:0]      o_rem_re,
    output logic [DEN_W-1:0]      o_rem_im,
    output logic [DATA_WIDTH-1:0] o_lo_re,
    output logic [DATA_WIDTH-1:0] o_lo_im,
    output logic [DATA_WIDTH-1:0] o_q_re,
    output logic [DATA_WIDTH-1:0] o_q_im
);

    localparam int W = DATA_WIDTH;

    logic             r_valid;
    wdb_pkg::t_flags  r_flags;
    logic [DEN_W-1:0] r_den, r_rem_re, r_rem_im;
    logic [W-1:0]     r_lo_re, r_lo_im, r_q_re, r_q_im;

    logic [DEN_W:0]   n_t_re, n_t_im;
    logic             n_ge_re, n_ge_im;
    logic [DEN_W-1:0] n_rem_re, n_rem_im;

    assign o_adv = !r_valid || i_adv;

    always_comb begin
        n_t_re   = {i_rem_re, i_lo_re[W-1]};
        n_t_im   = {i_rem_im, i_lo_im[W-1]};
        n_ge_re  = n_t_re >= {1'b0, i_den};
        n_ge_im  = n_t_im >= {1'b0, i_den};
        n_rem_re = n_ge_re ? DEN_W'(n_t_re - {1'b0, i_den}) : n_t_re[DEN_W-1:0];
        n_rem_im = n_ge_im ? DEN_W'(n_t_im - {1'b0, i_den}) : n_t_im[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_flags  <= i_flags;
            r_den    <= i_den;
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_lo_re  <= {i_lo_re[W-2:0], 1'b0};
            r_lo_im  <= {i_lo_im[W-2:0], 1'b0};
            r_q_re   <= {i_q_re[W-2:0], n_ge_re};
            r_q_im   <= {i_q_im[W-2:0], n_ge_im};
        end
    end

    assign o_valid  = r_valid;
    assign o_flags  = r_flags;
    assign o_den    = r_den;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_lo_re  = r_lo_re;
    assign o_lo_im  = r_lo_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;

endmodule

// ===== design/wiener_deconvolution_bin.sv =====
// ----------------------------------------------------------------------------
// wiener_deconvolution_bin : Wiener-regularised quotient of one FFT bin
// Returns S * conj(K) / (|K|^2 + noise_bias), saturated, with status flags.
// ----------------------------------------------------------------------------
// Usage:
//   i_bin carries one beat per bin: spectrum and kernel values, Q16.16.
//   o_res carries one beat per bin, in order: restored value, sat_flag when
//   either part was clipped, zero_div_flag when the denominator was zero.
//   i_cfg_we/i_cfg_data write noise_bias (unsigned Q16.16); write it only
//   while no bins are in flight.
//   Throughput: one bin per cycle while o_res is not stalled.
//   Path from input beat to output beat: four set-up stages, one divider
//   cell per quotient bit, and the output register.
//   Each stage holds its beat only while the stage after it is full and
//   held, so empty stages keep filling while o_res stalls; i_bin.ready
//   drops once the whole chain is full and stalled.
//   Reset empties every stage and sets noise_bias to 655.
// ----------------------------------------------------------------------------
module wiener_deconvolution_bin #(
    parameter int DATA_WIDTH = wdb_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wdb_in_if.sink                        i_bin,
    wdb_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [wdb_pkg::BIAS_W-1:0]    i_cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int DEN_W = wdb_pkg::den_width(DATA_WIDTH);

    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    logic [wdb_pkg::BIAS_W-1:0] r_noise_bias;

    logic             w_front_adv;
    logic             w_adv   [0:W];
    logic             w_valid [0:W];
    wdb_pkg::t_flags  w_flags [0:W];
    logic [DEN_W-1:0] w_den    [0:W];
    logic [DEN_W-1:0] w_rem_re [0:W];
    logic [DEN_W-1:0] w_rem_im [0:W];
    logic [W-1:0]     w_lo_re  [0:W];
    logic [W-1:0]     w_lo_im  [0:W];
    logic [W-1:0]     w_q_re   [0:W];
    logic [W-1:0]     w_q_im   [0:W];

    logic             w_out_adv;
    logic             r_out_valid;
    logic [W-1:0]     r_out_re, r_out_im;
    logic             r_out_sat, r_out_zero;

    logic [W-1:0]     n_out_re, n_out_im;
    logic             n_sat_re, n_sat_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_bias <= wdb_pkg::NOISE_BIAS_RST;
        end else if (i_cfg_we) begin
            r_noise_bias <= i_cfg_data;
        end
    end

    wdb_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_bin.valid),
        .o_adv        (w_front_adv),
        .i_spec_re    (i_bin.spec_re),
        .i_spec_im    (i_bin.spec_im),
        .i_kern_re    (i_bin.kern_re),
        .i_kern_im    (i_bin.kern_im),
        .i_noise_bias (r_noise_bias),
        .i_adv        (w_adv[0]),
        .o_valid      (w_valid[0]),
        .o_flags      (w_flags[0]),
        .o_den        (w_den[0]),
        .o_rem_re     (w_rem_re[0]),
        .o_rem_im     (w_rem_im[0]),
        .o_lo_re      (w_lo_re[0]),
        .o_lo_im      (w_lo_im[0])
    );

    assign i_bin.ready = w_front_adv;
    assign w_q_re[0]   = '0;
    assign w_q_im[0]   = '0;

    for (genvar k = 0; k < W; k++) begin : g_cell
        wdb_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[k]),
            .i_flags  (w_flags[k]),
            .i_den    (w_den[k]),
            .i_rem_re (w_rem_re[k]),
            .i_rem_im (w_rem_im[k]),
            .i_lo_re  (w_lo_re[k]),
            .i_lo_im  (w_lo_im[k]),
            .i_q_re   (w_q_re[k]),
            .i_q_im   (w_q_im[k]),
            .i_adv    (w_adv[k+1]),
            .o_adv    (w_adv[k]),
            .o_valid  (w_valid[k+1]),
            .o_flags  (w_flags[k+1]),
            .o_den    (w_den[k+1]),
            .o_rem_re (w_rem_re[k+1]),
            .o_rem_im (w_rem_im[k+1]),
            .o_lo_re  (w_lo_re[k+1]),
            .o_lo_im  (w_lo_im[k+1]),
            .o_q_re   (w_q_re[k+1]),
            .o_q_im   (w_q_im[k+1])
        );
    end

    assign w_out_adv = !r_out_valid || o_res.ready;
    assign w_adv[W]  = w_out_adv;

    always_comb begin
        n_sat_re = w_flags[W].ovf_re
                || (w_flags[W].neg_re ? (w_q_re[W] > LIM_NEG) : (w_q_re[W] > LIM_POS));
        n_sat_im = w_flags[W].ovf_im
                || (w_flags[W].neg_im ? (w_q_im[W] > LIM_NEG) : (w_q_im[W] > LIM_POS));
        if (n_sat_re) begin
            n_out_re = w_flags[W].neg_re ? LIM_NEG : LIM_POS;
        end else begin
            n_out_re = w_flags[W].neg_re ? (~w_q_re[W] + 1'b1) : w_q_re[W];
        end
        if (n_sat_im) begin
            n_out_im = w_flags[W].neg_im ? LIM_NEG : LIM_POS;
        end else begin
            n_out_im = w_flags[W].neg_im ? (~w_q_im[W] + 1'b1) : w_q_im[W];
        end
        if (w_flags[W].zero_den) begin
            n_out_re = '0;
            n_out_im = '0;
            n_sat_re = 1'b0;
            n_sat_im = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_out_re   <= n_out_re;
            r_out_im   <= n_out_im;
            r_out_sat  <= n_sat_re || n_sat_im;
            r_out_zero <= w_flags[W].zero_den;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.out_re        = r_out_re;
    assign o_res.out_im        = r_out_im;
    assign o_res.sat_flag      = r_out_sat;
    assign o_res.zero_div_flag = r_out_zero;

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_bin.ready)
        else $error("input stalled with an empty output register");

    a_zero_div_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.zero_div_flag) |->
            (o_res.out_re == '0 && o_res.out_im == '0 && !o_res.sat_flag))
        else $error("zero denominator beat carries a non-zero payload");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_noise_bias == $past(i_cfg_data)))
        else $error("noise bias write lost");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.sat_flag && !o_res.zero_div_flag && $past(w_out_adv))
            |-> $past(!w_flags[W].ovf_re && !w_flags[W].ovf_im))
        else $error("quotient overflow without saturation flag");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for wiener_deconvolution_bin
// A table of hand-picked bins (zero, unit and extreme kernels, clipping,
// zero denominator) is followed by random bins under several noise_bias
// settings. Each accepted input beat is scored against a hand-typed result or an
// exact wide-integer Wiener quotient. Both channels stall at random, and once the
// result side holds off long enough to back the chain up into the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int DW = wdb_pkg::DATA_WIDTH_DEF;
    localparam logic [DW-1:0] ONE  = 32'h0001_0000;
    localparam logic [DW-1:0] MONE = 32'hFFFF_0000;
    localparam logic [DW-1:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] MINN = 32'h8000_0000;
    localparam logic [DW-1:0] CORNERS [7] = '{32'h0, 32'h1, 32'hFFFF_FFFF, ONE, MONE, MAXP, MINN};

    typedef struct packed {
        logic signed [DW-1:0] spec_re;
        logic signed [DW-1:0] spec_im;
        logic signed [DW-1:0] kern_re;
        logic signed [DW-1:0] kern_im;
    } t_bin;

    typedef struct packed {
        logic signed [DW-1:0] out_re;
        logic signed [DW-1:0] out_im;
        logic                 sat_flag;
        logic                 zero_div_flag;
    } t_res;

    typedef struct {
        logic [wdb_pkg::BIAS_W-1:0] bias;
        t_bin                       bin;
        bit                         typed;
        t_res                       res;
    } t_probe;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [wdb_pkg::BIAS_W-1:0] cfg_data = '0;
    logic [wdb_pkg::BIAS_W-1:0] bias_now = wdb_pkg::NOISE_BIAS_RST;
    bit                         calm = 1'b0;
    bit                         squeeze = 1'b0;
    int                         fails = 0;
    t_res                       restored_q [$];
    t_res                       due;

    t_probe probes [19] = '{
        '{32'd655, '{32'h0, 32'h0, 32'h0, 32'h0},   1'b1, '{32'h0, 32'h0, 1'b0, 1'b0}},
        '{32'd655, '{MAXP, MINN, ONE, 32'h0},       1'b0, '0},
        '{32'd655, '{ONE, ONE, MINN, MINN},         1'b0, '0},
        '{32'h0,   '{MAXP, MINN, 32'h0, 32'h0},     1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
        '{32'h0,   '{32'h0, 32'h0, 32'h0, 32'h0},   1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
        '{32'h0,   '{MAXP, MINN, ONE, 32'h0},       1'b1, '{MAXP, MINN, 1'b0, 1'b0}},
        '{32'h0,   '{MINN, MAXP, MONE, 32'h0},      1'b1, '{MAXP, 32'h8000_0001, 1'b1, 1'b0}},
        '{32'h0,   '{ONE, MONE, 32'h1, 32'h0},      1'b1, '{MAXP, MINN, 1'b1, 1'b0}},
        '{32'h0,   '{ONE, 32'h0, 32'h0003_0000, 32'h0},  1'b0, '0},
        '{32'h0,   '{MONE, 32'h0, 32'h0003_0000, 32'h0}, 1'b0, '0},
        '{32'h0,   '{32'h1, 32'hFFFF_FFFF, MAXP, MAXP},  1'b0, '0},
        '{32'h0,   '{MINN, MINN, MINN, MINN},       1'b0, '0},
        '{32'h0,   '{MAXP, MAXP, MAXP, MAXP},       1'b0, '0},
        '{32'h0,   '{32'h0, 32'h0, 32'h0, 32'h1},   1'b1, '{32'h0, 32'h0, 1'b0, 1'b0}},
        '{32'hFFFF_FFFF, '{MAXP, MINN, 32'h0, 32'h0}, 1'b0, '0},
        '{32'hFFFF_FFFF, '{MINN, MAXP, MINN, MAXP},   1'b0, '0},
        '{32'hFFFF_FFFF, '{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b0}},
        '{32'h1,   '{MAXP, MINN, 32'h1, 32'h0},     1'b0, '0},
        '{ONE,     '{ONE, ONE, ONE, MONE},          1'b0, '0}
    };

    wdb_in_if  #(.DATA_WIDTH(DW)) bin_if ();
    wdb_out_if #(.DATA_WIDTH(DW)) res_if ();

    wiener_deconvolution_bin #(.DATA_WIDTH(DW)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_bin      (bin_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [DW-1:0] fit_q(input logic signed [79:0] num,
                                            input logic [79:0] den, output logic clipped);
        logic        neg;
        logic [95:0] mag;
        logic [95:0] q;
        logic [95:0] lim;
        neg = num[79];
        mag = {16'd0, neg ? -num : num};
        q = (mag << wdb_pkg::FRAC_BITS) / {16'd0, den};
        lim = neg ? (96'd1 << (DW - 1)) : (96'd1 << (DW - 1)) - 96'd1;
        clipped = q > lim;
        if (clipped) begin
            q = lim;
        end
        return neg ? (~q[DW-1:0] + 1'b1) : q[DW-1:0];
    endfunction

    function automatic t_res wiener_bin(input t_bin b, input logic [wdb_pkg::BIAS_W-1:0] bias);
        logic signed [79:0] sr;
        logic signed [79:0] si;
        logic signed [79:0] kr;
        logic signed [79:0] ki;
        logic [79:0]        den;
        logic               clip_re;
        logic               clip_im;
        t_res               r;
        sr = b.spec_re;
        si = b.spec_im;
        kr = b.kern_re;
        ki = b.kern_im;
        den = kr * kr + ki * ki + ({48'd0, bias} << wdb_pkg::FRAC_BITS);
        r = '0;
        if (den == 0) begin
            r.zero_div_flag = 1'b1;
        end else begin
            r.out_re = fit_q(sr * kr + si * ki, den, clip_re);
            r.out_im = fit_q(si * kr - sr * ki, den, clip_im);
            r.sat_flag = clip_re | clip_im;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DW-1:0] rand_field();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                v = CORNERS[$urandom_range(0, 6)];
            end
            1, 2: begin
                v = $urandom;
            end
            default: begin
                v = $signed($urandom) >>> $urandom_range(1, DW - 1);
            end
        endcase
        return v;
    endfunction

    function automatic t_bin rand_bin();
        t_bin b;
        b.spec_re = rand_field();
        b.spec_im = rand_field();
        b.kern_re = rand_field();
        b.kern_im = rand_field();
        if ($urandom_range(0, 15) == 0) begin
            b.kern_re = '0;
            b.kern_im = '0;
        end
        return b;
    endfunction

    task automatic push_bin(input t_bin b, input t_res want);
        int n;
        bin_if.valid   <= 1'b1;
        bin_if.spec_re <= b.spec_re;
        bin_if.spec_im <= b.spec_im;
        bin_if.kern_re <= b.kern_re;
        bin_if.kern_im <= b.kern_im;
        @(posedge clk);
        while (!bin_if.ready) @(posedge clk);
        restored_q.push_back(want);
        n = pick_gap();
        if (n > 0) begin
            bin_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic settle();
        bin_if.valid <= 1'b0;
        while (restored_q.size() != 0) @(posedge clk);
    endtask

    task automatic load_bias(input logic [wdb_pkg::BIAS_W-1:0] v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        bias_now = v;
    endtask

    initial begin : stimulus
        t_bin                       b;
        t_res                       want;
        logic [wdb_pkg::BIAS_W-1:0] v;
        bin_if.valid   <= 1'b0;
        bin_if.spec_re <= '0;
        bin_if.spec_im <= '0;
        bin_if.kern_re <= '0;
        bin_if.kern_im <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        foreach (probes[i]) begin
            if (probes[i].bias != bias_now) begin
                load_bias(probes[i].bias);
            end
            want = probes[i].typed ? probes[i].res : wiener_bin(probes[i].bin, bias_now);
            push_bin(probes[i].bin, want);
        end
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: v = '0;
                1: v = '1;
                2: v = 32'h1;
                3: v = $urandom_range(0, 32'hFFFF);
                4: v = $urandom;
                default: v = wdb_pkg::NOISE_BIAS_RST;
            endcase
            load_bias(v);
            for (int k = 0; k < 280; k++) begin
                if (k % 70 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                // back the chain up into the input
                if (ph == 1 && k == 100) begin
                    calm = 1'b1;
                    squeeze = 1'b1;
                end
                b = rand_bin();
                push_bin(b, wiener_bin(b, bias_now));
            end
        end
        settle();
        repeat (DW + 8) @(posedge clk);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_stall
        int n;
        res_if.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (squeeze) begin
                n = 150;
                squeeze = 1'b0;
            end else begin
                n = pick_gap();
            end
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (restored_q.size() == 0) begin
                $error("result beat with nothing expected");
                fails++;
            end else begin
                due = restored_q.pop_front();
                if (res_if.out_re !== due.out_re) begin
                    $error("out_re: expected %h, got %h", due.out_re, res_if.out_re);
                    fails++;
                end
                if (res_if.out_im !== due.out_im) begin
                    $error("out_im: expected %h, got %h", due.out_im, res_if.out_im);
                    fails++;
                end
                if (res_if.sat_flag !== due.sat_flag) begin
                    $error("sat_flag: expected %b, got %b", due.sat_flag, res_if.sat_flag);
                    fails++;
                end
                if (res_if.zero_div_flag !== due.zero_div_flag) begin
                    $error("zero_div_flag: expected %b, got %b",
                           due.zero_div_flag, res_if.zero_div_flag);
                    fails++;
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/wdb_pkg.sv
design/wdb_in_if.sv
design/wdb_out_if.sv
design/wdb_front.sv
design/wdb_cell.sv
design/wiener_deconvolution_bin.sv
tb/sv/tb.sv
